FILE: src/bcba_pkg.sv
`timescale 1ns / 1ps

package bcba_pkg;

    // allocator geometry
    localparam int BLOCK_COUNT = 4096;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORD_COUNT  = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIDX_W      = WIDX_W + BIT_W;
    localparam int BLK_W       = $clog2(BLOCK_COUNT);
    localparam int LAST_BITS   = BLOCK_COUNT - (WORD_COUNT - 1) * WORD_W;

    // field widths
    localparam int COUNT_W = 13;
    localparam int LINK_W  = 16;
    localparam int START_W = 12;

    localparam logic [LINK_W-1:0] CHAIN_END = 16'hFFFF;
    localparam logic [LINK_W:0]   BLOCK_LIMIT = (LINK_W + 1)'(BLOCK_COUNT);

    // valid bits of the last bitmap word
    localparam logic [WORD_W-1:0] LAST_MASK =
        (LAST_BITS == WORD_W) ? {WORD_W{1'b1}}
                              : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    typedef struct packed {
        logic [COUNT_W-1:0] request_count;
        logic [LINK_W-1:0]  chain_tail;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [LINK_W-1:0]  chain_start;
        logic [COUNT_W-1:0] granted_count;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic take;
        logic write_back;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic has_free;
        logic count_met;
        logic last_word;
    } sts_t;

endpackage

FILE: src/bitmap_chain_block_allocator.sv
`timescale 1ns / 1ps

// First-fit block allocator over a 4096-block used map with a linked chain
// table. Raise start while busy is low to hand in one request; the result
// appears on result for exactly one cycle with done high and must be taken
// then, as the block cannot be held off. For each 32-bit bitmap word that
// the scan visits, the word is read, its free blocks are taken in turn, and
// the word is written back; a request is accepted in the idle state and
// reported in the done state. The bitmap word memory is read and written in
// separate steps. data_start may be written through cfg_we/cfg_wdata while
// no request is in flight.
module bitmap_chain_block_allocator
    import bcba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               request,
    output logic               done,
    output res_t               result,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    bcba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // bitmap, link table and transaction registers
    bcba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

FILE: src/bcba_ctrl.sv
`timescale 1ns / 1ps

module bcba_ctrl
    import bcba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.skip ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!sts.count_met && sts.has_free)
                begin
                    cmd.take = 1'b1;
                end
                else
                begin
                    cmd.write_back = 1'b1;
                    state_next = (sts.count_met || sts.last_word) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/bcba_datapath.sv
`timescale 1ns / 1ps

module bcba_datapath
    import bcba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [START_W-1:0] cfg_wdata,
    input  req_t               request,
    input  cmd_t               cmd,
    output sts_t               sts,
    output res_t               result
);

    logic [START_W-1:0] data_start_reg;
    logic [COUNT_W-1:0] want_reg;
    logic [COUNT_W-1:0] got_reg;
    logic [LINK_W-1:0]  start_reg;
    logic [LINK_W-1:0]  prev_reg;
    logic               have_prev_reg;
    logic [WIDX_W-1:0]  word_idx_reg;
    logic [BIT_W-1:0]   start_bit_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [WORD_COUNT-1:0] valid_reg;

    logic [WORD_W-1:0] map_mem [WORD_COUNT];
    logic [LINK_W-1:0] link_mem [BLOCK_COUNT];

    logic [WORD_W-1:0] cand;
    logic [BIT_W-1:0]  pick;
    logic [BIDX_W-1:0] blk;
    logic              last_word;
    logic              prev_in_range;
    logic              link_we;
    logic [LINK_W-1:0] link_wdata;

    // scan status
    assign last_word = (word_idx_reg == WIDX_W'(WORD_COUNT - 1));
    assign cand = ~word_reg & ({WORD_W{1'b1}} << start_bit_reg)
                  & (last_word ? LAST_MASK : {WORD_W{1'b1}});

    // lowest free bit of the word
    always_comb
    begin
        pick = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick = BIT_W'(i);
            end
        end
    end

    assign blk           = {word_idx_reg, pick};
    assign prev_in_range = ({1'b0, prev_reg} < BLOCK_LIMIT);

    assign sts.skip      = (request.request_count == '0)
                           || ((LINK_W + 1)'(data_start_reg) >= BLOCK_LIMIT);
    assign sts.has_free  = (cand != '0);
    assign sts.count_met = (got_reg == want_reg);
    assign sts.last_word = last_word;

    // link write: previous block points at the new one, or closes the chain
    always_comb
    begin
        link_we    = 1'b0;
        link_wdata = CHAIN_END;
        if (cmd.take && have_prev_reg && prev_in_range)
        begin
            link_we    = 1'b1;
            link_wdata = LINK_W'(blk);
        end
        else if (cmd.finish && (got_reg != '0))
        begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[prev_reg[BLK_W-1:0]] <= link_wdata;
        end
    end

    // bitmap memory, one word per entry
    always_ff @(posedge clk)
    begin
        if (cmd.write_back)
        begin
            map_mem[word_idx_reg] <= word_reg;
        end
    end

    // working word: registered read, updated as blocks are taken
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            word_reg <= valid_reg[word_idx_reg] ? map_mem[word_idx_reg] : '0;
        end
        else if (cmd.take)
        begin
            word_reg <= word_reg | (WORD_W'(1) << pick);
        end
    end

    // word valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_back)
        begin
            valid_reg[word_idx_reg] <= 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            data_start_reg <= cfg_wdata;
        end
    end

    // transaction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_reg      <= '0;
            got_reg       <= '0;
            start_reg     <= CHAIN_END;
            prev_reg      <= CHAIN_END;
            have_prev_reg <= 1'b0;
            word_idx_reg  <= '0;
            start_bit_reg <= '0;
        end
        else if (cmd.load)
        begin
            want_reg      <= request.request_count;
            got_reg       <= '0;
            start_reg     <= request.chain_tail;
            prev_reg      <= request.chain_tail;
            have_prev_reg <= (request.chain_tail != CHAIN_END);
            word_idx_reg  <= WIDX_W'(data_start_reg >> BIT_W);
            start_bit_reg <= data_start_reg[BIT_W-1:0];
        end
        else if (cmd.take)
        begin
            if (!have_prev_reg)
            begin
                start_reg <= LINK_W'(blk);
            end
            prev_reg      <= LINK_W'(blk);
            have_prev_reg <= 1'b1;
            got_reg       <= got_reg + COUNT_W'(1);
        end
        else if (cmd.write_back && !last_word)
        begin
            word_idx_reg  <= word_idx_reg + WIDX_W'(1);
            start_bit_reg <= '0;
        end
    end

    // result
    assign result.success       = (got_reg == want_reg);
    assign result.chain_start   = start_reg;
    assign result.granted_count = got_reg;

endmodule
